/* rtl/pse_pkg.sv */
`default_nettype none

package pse_pkg;

  localparam int unsigned TABLE_SIZE  = 256;
  localparam int unsigned MIN_LIMIT   = 3;
  localparam int unsigned FIRST_PRIME = 2;
  // Every composite below TABLE_SIZE has a factor among the first six primes (2..13)
  localparam int unsigned NUM_CELLS   = 6;
  localparam int unsigned LIMIT_W     = 9;
  localparam int unsigned VALUE_W     = 8;
  localparam int unsigned MULT_W      = 9;

  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [MULT_W-1:0]  mult_t;

  // One candidate moving down the cell row
  typedef struct packed {
    logic   valid;
    logic   alive;
    logic   claimed;
    logic   final_tok;
    value_t value;
  } token_t;

endpackage

`default_nettype wire

/* rtl/pse_cell.sv */
`default_nettype none

module pse_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  pse_pkg::token_t tok_i,
  output pse_pkg::token_t tok_o
);
  import pse_pkg::*;

  logic   own_v_q, own_v_d;
  value_t p_q, p_d;
  mult_t  mult_q, mult_d;
  token_t tok_q, tok_d;

  always_comb begin
    own_v_d = own_v_q;
    p_d     = p_q;
    mult_d  = mult_q;
    tok_d   = tok_i;
    if (tok_i.valid) begin
      if (!own_v_q) begin
        // first surviving candidate to reach an empty cell is a prime: keep it
        if (tok_i.alive && !tok_i.claimed) begin
          own_v_d       = 1'b1;
          p_d           = tok_i.value;
          mult_d        = {tok_i.value, 1'b0};
          tok_d.claimed = 1'b1;
        end
      end else if ({1'b0, tok_i.value} == mult_q) begin
        // every value passes, so the multiple advances exactly once per hit
        tok_d.alive = 1'b0;
        mult_d      = mult_q + {1'b0, p_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_v_q <= 1'b0;
      tok_q   <= '0;
    end else if (clear_i) begin
      own_v_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      own_v_q <= own_v_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    mult_q <= mult_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

/* rtl/pse_emit.sv */
`default_nettype none

module pse_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pse_pkg::token_t tok_i,
  output logic            result_valid_o,
  output pse_pkg::value_t prime_o,
  output logic            last_o,
  output logic            done_o
);
  import pse_pkg::*;

  value_t pend_q;
  logic   pend_v_q;
  logic   flush_q;
  logic   take;

  assign take = tok_i.valid & tok_i.alive;

  // hold each prime one step so the largest one can carry the last flag
  assign result_valid_o = flush_q | (take & pend_v_q);
  assign prime_o        = pend_q;
  assign last_o         = flush_q;
  assign done_o         = flush_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      flush_q  <= 1'b0;
    end else begin
      flush_q <= tok_i.valid & tok_i.final_tok;
      if (take) begin
        pend_v_q <= 1'b1;
      end else if (flush_q) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_q <= tok_i.value;
    end
  end

endmodule

`default_nettype wire

/* rtl/prime_sieve_engine.sv */
// One candidate enters the cell row per cycle, and a run ends when the candidate limit-1
// (after clamping) leaves the six-cell row and the emit stage; a new start is taken only
// while busy is low, so runs do not overlap.
// Results are one-cycle strobes; the receiver cannot stall, and busy stays high until
// the result flagged last has been shown. Reset clears control state and sets limit to 25.
`default_nettype none

module prime_sieve_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  pse_pkg::limit_t       cfg_limit_i,
  input  logic                  start,
  input  logic                  start_req_i,
  output logic                  busy,
  output logic                  result_valid_o,
  output pse_pkg::value_t       prime_o,
  output logic                  last_o
);
  import pse_pkg::*;

  limit_t limit_q;
  logic   busy_q;
  logic   feed_q;
  value_t v_q;
  value_t lim_m1_q;
  value_t lim_m1;
  limit_t limit_dec;
  logic   accept;
  logic   run;
  logic   done;
  logic   feed_end;
  token_t chain [NUM_CELLS+1];

  assign busy   = busy_q;
  assign accept = start & ~busy_q;
  assign run    = accept & start_req_i;

  // saturate the limit into the supported range
  assign limit_dec = limit_q - limit_t'(1);
  always_comb begin
    if (limit_q > limit_t'(TABLE_SIZE)) begin
      lim_m1 = value_t'(TABLE_SIZE - 1);
    end else if (limit_q < limit_t'(MIN_LIMIT)) begin
      lim_m1 = value_t'(MIN_LIMIT - 1);
    end else begin
      lim_m1 = limit_dec[VALUE_W-1:0];
    end
  end

  assign feed_end = (v_q == lim_m1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= limit_t'(25);
      busy_q  <= 1'b0;
      feed_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_limit_i;
      end
      if (run) begin
        busy_q <= 1'b1;
        feed_q <= 1'b1;
      end else begin
        if (done) begin
          busy_q <= 1'b0;
        end
        if (feed_q && feed_end) begin
          feed_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      v_q      <= value_t'(FIRST_PRIME);
      lim_m1_q <= lim_m1;
    end else if (feed_q) begin
      v_q <= v_q + value_t'(1);
    end
  end

  always_comb begin
    chain[0].valid     = feed_q;
    chain[0].alive     = 1'b1;
    chain[0].claimed   = 1'b0;
    chain[0].final_tok = feed_end;
    chain[0].value     = v_q;
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    pse_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (run),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1])
    );
  end

  pse_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_i          (chain[NUM_CELLS]),
    .result_valid_o (result_valid_o),
    .prime_o        (prime_o),
    .last_o         (last_o),
    .done_o         (done)
  );

endmodule

`default_nettype wire

/* rtl/pse_checker.sv */
`default_nettype none

module pse_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            start_req_i,
  input logic            busy,
  input logic            result_valid_o,
  input logic            last_o
);

  a_result_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result transfer outside a run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !busy)
    else $error("busy still high after last transfer");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !(result_valid_o && last_o)) |=> busy)
    else $error("run ended without a last transfer");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && start_req_i) |=> busy)
    else $error("start request did not begin a run");

  a_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !start_req_i) |=> (!busy && !result_valid_o))
    else $error("empty start request changed state");

endmodule

bind prime_sieve_engine pse_checker u_pse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .start_req_i    (start_req_i),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .last_o         (last_o)
);

`default_nettype wire
